FILE: rtl/core/mah_pkg.sv
// Shared types, constants and lookup tables for the MPEG audio header decoder.
`timescale 1ns / 1ps
`default_nettype none

package mah_pkg;

    localparam int QUO_W = 12;
    localparam int NUM_W = 26;
    localparam int DIV_W = 16;
    localparam int REM_W = NUM_W + 1;
    localparam int KBPS_W = 9;

    localparam logic [1:0] ST_INVALID = 2'd0;
    localparam logic [1:0] ST_FRAME   = 2'd1;
    localparam logic [1:0] ST_TAG     = 2'd2;
    localparam logic [1:0] ST_FREE_L3 = 2'd3;

    localparam logic [23:0] TAG_WORD    = 24'h544147;
    localparam logic [11:0] TAG_LENGTH  = 12'd128;
    localparam logic [3:0]  BR_BAD      = 4'hf;
    localparam logic [3:0]  BR_FREE     = 4'h0;
    localparam logic [1:0]  SR_BAD      = 2'b11;
    localparam logic [1:0]  LAY_BAD     = 2'b00;
    localparam logic [1:0]  LAY_L1      = 2'b11;
    localparam logic [1:0]  LAY_L2      = 2'b10;
    localparam logic [1:0]  LAY_L3      = 2'b01;

    localparam logic [NUM_W-1:0] L1_SCALE  = 26'd12000;
    localparam logic [NUM_W-1:0] L23_SCALE = 26'd144000;

    // kbps at row 3*lsf + layer-1, column index; rows of 16, index 15 unused
    localparam logic [KBPS_W-1:0] KBPS_TABLE [96] = '{
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0,
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0,
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0,
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0,
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0,
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0
    };

    typedef struct packed {
        logic [1:0] status;
        logic       use_div;
        logic       pad;
        logic       quad;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsh;
        logic [QUO_W-1:0] quo;
        side_t            side;
    } cell_t;

    function automatic logic [DIV_W-1:0] sample_rate(input logic [3:0] sel);
        logic [DIV_W-1:0] r;
        unique case (sel)
            4'd0:    r = 16'd44100;
            4'd1:    r = 16'd48000;
            4'd2:    r = 16'd32000;
            4'd3:    r = 16'd22050;
            4'd4:    r = 16'd24000;
            4'd5:    r = 16'd16000;
            4'd6:    r = 16'd11025;
            4'd7:    r = 16'd12000;
            4'd8:    r = 16'd8000;
            default: r = 16'd44100;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mpeg_audio_header_decoder.sv
// Top level of the MPEG audio frame header decoder: decode cell, divider chain, output register.
//
// Usage:
//   Input channel: header_word with in_valid/in_ready. Each word is four
//   consecutive stream bytes, first byte in bits 31..24. One transfer in
//   gives exactly one transfer out on status/frame_length with
//   out_valid/out_ready, in order.
//   Pipeline: one decode cell (field split, bitrate and sample-rate tables,
//   constant multiply), then a row of 12 identical divider cells, each
//   resolving one quotient bit of bitrate*scale/rate, then the output
//   register that adds padding and scales layer I lengths.
//   Throughput: one word per cycle while out_ready is high; the 13-stage
//   cell row and the output register can each load while the next hands off.
//   Stall: each stage holds its contents while the next one is full and
//   not draining, so bubbles fill up before in_ready drops; with the output
//   register empty, in_ready is always high.
//   Reset: rst_n clears every valid bit at once; no result is pending after.
`timescale 1ns / 1ps
`default_nettype none

module mpeg_audio_header_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] header_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [11:0]      frame_length
);

    localparam int N_CELLS = mah_pkg::QUO_W;

    // stage 0 is the decode cell, stage k (k >= 1) the k-th divider cell
    mah_pkg::cell_t  stg_data  [N_CELLS + 1];
    logic            stg_valid [N_CELLS + 1];
    logic            stg_ready [N_CELLS + 1];

    logic                        out_valid_reg;
    logic [1:0]                  status_reg;
    logic [11:0]                 length_reg;
    logic [11:0]                 length_next;
    logic [mah_pkg::QUO_W-1:0]   quo_pad;
    mah_pkg::cell_t              last;
    logic                        last_ready;

    mah_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .up_valid    (in_valid),
        .up_ready    (in_ready),
        .header_word (header_word),
        .down_valid  (stg_valid[0]),
        .down_ready  (stg_ready[0]),
        .down_data   (stg_data[0])
    );

    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        mah_div_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (stg_valid[k]),
            .up_ready   (stg_ready[k]),
            .up_data    (stg_data[k]),
            .down_valid (stg_valid[k + 1]),
            .down_ready (stg_ready[k + 1]),
            .down_data  (stg_data[k + 1])
        );
    end

    assign last       = stg_data[N_CELLS];
    assign last_ready = !out_valid_reg || out_ready;
    assign stg_ready[N_CELLS] = last_ready;

    // padding adds one slot: four bytes in layer I, one byte otherwise
    always_comb
    begin
        quo_pad = last.quo + {{(mah_pkg::QUO_W - 1){1'b0}}, last.side.pad};
        if (last.side.status == mah_pkg::ST_TAG)
            length_next = mah_pkg::TAG_LENGTH;
        else if (last.side.use_div)
            length_next = last.side.quad ? {quo_pad[9:0], 2'b00} : quo_pad;
        else
            length_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (last_ready)
            out_valid_reg <= stg_valid[N_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (last_ready && stg_valid[N_CELLS])
        begin
            status_reg <= last.side.status;
            length_reg <= length_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign frame_length = length_reg;

`ifndef SYNTHESIS
    a_tag_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == mah_pkg::ST_TAG |-> frame_length == mah_pkg::TAG_LENGTH)
        else $error("tag result without 128-byte length");

    a_invalid_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == mah_pkg::ST_INVALID || status == mah_pkg::ST_FREE_L3)
        |-> frame_length == 12'd0)
        else $error("nonzero length on invalid or free-format result");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !stg_valid[N_CELLS] |=> !out_valid)
        else $error("output valid without a result from the cell row");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/mah_decode.sv
// Front cell: field decode, table lookups and dividend/divisor setup.
`timescale 1ns / 1ps
`default_nettype none

module mah_decode (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire logic [31:0]     header_word,
    output logic                 down_valid,
    input  wire logic            down_ready,
    output mah_pkg::cell_t       down_data
);

    logic                 valid_reg;
    mah_pkg::cell_t       data_reg;
    mah_pkg::cell_t       data_next;

    logic                        tag_hit;
    logic                        bad;
    logic [3:0]                  br_idx;
    logic [1:0]                  sr_idx;
    logic [1:0]                  lay_code;
    logic                        lsf;
    logic [3:0]                  rate_sel;
    logic [6:0]                  row_base;
    logic [mah_pkg::KBPS_W-1:0]  kbps;
    logic [mah_pkg::DIV_W-1:0]   rate;
    logic [mah_pkg::DIV_W-1:0]   divisor;
    logic [mah_pkg::NUM_W-1:0]   kbps_w;
    logic [mah_pkg::NUM_W-1:0]   numer;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        tag_hit  = header_word[31:8] == mah_pkg::TAG_WORD;
        br_idx   = header_word[15:12];
        sr_idx   = header_word[11:10];
        lay_code = header_word[18:17];
        bad      = !(&header_word[31:21]) || br_idx == mah_pkg::BR_BAD
                   || sr_idx == mah_pkg::SR_BAD || lay_code == mah_pkg::LAY_BAD;

        // MPEG2.5 when bit 20 is clear
        if (header_word[20])
        begin
            lsf      = !header_word[19];
            rate_sel = {2'b00, sr_idx} + (lsf ? 4'd3 : 4'd0);
        end
        else
        begin
            lsf      = 1'b1;
            rate_sel = 4'd6 + {2'b00, sr_idx};
        end
        rate = mah_pkg::sample_rate(rate_sel);

        unique case (lay_code)
            mah_pkg::LAY_L1: row_base = lsf ? 7'd48 : 7'd0;
            mah_pkg::LAY_L2: row_base = lsf ? 7'd64 : 7'd16;
            default:         row_base = lsf ? 7'd80 : 7'd32;
        endcase
        kbps   = mah_pkg::KBPS_TABLE[row_base + {3'b000, br_idx}];
        kbps_w = {{(mah_pkg::NUM_W - mah_pkg::KBPS_W){1'b0}}, kbps};

        if (lay_code == mah_pkg::LAY_L1)
            numer = kbps_w * mah_pkg::L1_SCALE;
        else
            numer = kbps_w * mah_pkg::L23_SCALE;

        divisor = (lay_code == mah_pkg::LAY_L3 && lsf) ? {rate[14:0], 1'b0} : rate;

        data_next.rem  = {1'b0, numer};
        data_next.dsh  = {divisor, {(mah_pkg::QUO_W - 1){1'b0}}};
        data_next.quo  = '0;
        data_next.side.pad  = header_word[9];
        data_next.side.quad = lay_code == mah_pkg::LAY_L1;

        if (tag_hit)
        begin
            data_next.side.status  = mah_pkg::ST_TAG;
            data_next.side.use_div = 1'b0;
        end
        else if (bad)
        begin
            data_next.side.status  = mah_pkg::ST_INVALID;
            data_next.side.use_div = 1'b0;
        end
        else if (br_idx == mah_pkg::BR_FREE)
        begin
            data_next.side.status  = (lay_code == mah_pkg::LAY_L3) ? mah_pkg::ST_FREE_L3
                                                                   : mah_pkg::ST_FRAME;
            data_next.side.use_div = 1'b0;
        end
        else
        begin
            data_next.side.status  = mah_pkg::ST_FRAME;
            data_next.side.use_div = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/mah_div_cell.sv
// One restoring-division cell: resolves one quotient bit and passes on.
`timescale 1ns / 1ps
`default_nettype none

module mah_div_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output logic                 up_ready,
    input  wire mah_pkg::cell_t  up_data,
    output logic                 down_valid,
    input  wire logic            down_ready,
    output mah_pkg::cell_t       down_data
);

    logic            valid_reg;
    mah_pkg::cell_t  data_reg;
    mah_pkg::cell_t  data_next;
    logic            ge;

    assign up_ready   = !valid_reg || down_ready;
    assign down_valid = valid_reg;
    assign down_data  = data_reg;

    always_comb
    begin
        ge             = up_data.rem >= up_data.dsh;
        data_next      = up_data;
        data_next.rem  = ge ? up_data.rem - up_data.dsh : up_data.rem;
        data_next.dsh  = {1'b0, up_data.dsh[mah_pkg::REM_W-1:1]};
        data_next.quo  = {up_data.quo[mah_pkg::QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            data_reg <= data_next;
    end

endmodule

`default_nettype wire

FILE: tb/mpeg_audio_header_decoder_tb.sv
// Self-checking testbench for the MPEG audio frame header decoder.
`timescale 1ns / 1ps

module mpeg_audio_header_decoder_tb;

    // Scales of the frame length formulas (slot units per kbps)
    localparam int unsigned L1_SLOT_SCALE  = 12000;
    localparam int unsigned L23_SLOT_SCALE = 144000;
    localparam logic [31:0] SYNC_BITS      = 32'hffe00000;

    localparam int unsigned RANDOM_WORDS   = 1525;
    localparam int unsigned CALM_SPAN      = 150;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] length;
    } hdr_result_t;

    typedef struct {
        logic [31:0] word;
        hdr_result_t res;
    } hdr_expect_t;

    // One directed row; typed rows carry their expected result inline
    typedef struct {
        logic [31:0] word;
        bit          typed;
        hdr_result_t res;
    } hdr_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] header_word;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [11:0] frame_length;

    // Expected decodes, oldest first
    hdr_expect_t pending_headers[$];
    hdr_row_t    header_rows[$];

    int unsigned fail_count;
    int unsigned idle_cycles;
    int unsigned sink_hold;
    int unsigned sink_roll;
    logic        calm;

    mpeg_audio_header_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .header_word  (header_word),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .frame_length (frame_length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Decode predictor
    // ------------------------------------------------------------------

    // Bitrate in kbps; lsf covers both MPEG2 and MPEG2.5
    function automatic int unsigned kbps_of(input logic lsf, input logic [1:0] lay,
                                            input logic [3:0] idx);
        int unsigned i;
        int unsigned k;
        i = idx;
        k = 0;
        if (idx == mah_pkg::BR_BAD)
            k = 0;
        else if (!lsf && lay == mah_pkg::LAY_L1)
            k = 32 * i;
        else if (!lsf && lay == mah_pkg::LAY_L2)
        begin
            case (idx)
                4'd1:    k = 32;
                4'd2:    k = 48;
                4'd3:    k = 56;
                4'd4:    k = 64;
                4'd5:    k = 80;
                4'd6:    k = 96;
                4'd7:    k = 112;
                4'd8:    k = 128;
                4'd9:    k = 160;
                4'd10:   k = 192;
                4'd11:   k = 224;
                4'd12:   k = 256;
                4'd13:   k = 320;
                4'd14:   k = 384;
                default: k = 0;
            endcase
        end
        else if (!lsf)
        begin
            case (idx)
                4'd1:    k = 32;
                4'd2:    k = 40;
                4'd3:    k = 48;
                4'd4:    k = 56;
                4'd5:    k = 64;
                4'd6:    k = 80;
                4'd7:    k = 96;
                4'd8:    k = 112;
                4'd9:    k = 128;
                4'd10:   k = 160;
                4'd11:   k = 192;
                4'd12:   k = 224;
                4'd13:   k = 256;
                4'd14:   k = 320;
                default: k = 0;
            endcase
        end
        else if (lay == mah_pkg::LAY_L1)
        begin
            case (idx)
                4'd1:    k = 32;
                4'd2:    k = 48;
                4'd3:    k = 56;
                4'd4:    k = 64;
                4'd5:    k = 80;
                4'd6:    k = 96;
                4'd7:    k = 112;
                4'd8:    k = 128;
                4'd9:    k = 144;
                4'd10:   k = 160;
                4'd11:   k = 176;
                4'd12:   k = 192;
                4'd13:   k = 224;
                4'd14:   k = 256;
                default: k = 0;
            endcase
        end
        else
            // LSF layers II/III: 8 kbps steps up to 64, then 16 kbps steps
            k = (i <= 8) ? 8 * i : 16 * (i - 4);
        return k;
    endfunction

    function automatic hdr_result_t predict_header(input logic [31:0] w);
        hdr_result_t res;
        logic [3:0]  br_idx;
        logic [1:0]  sr_idx;
        logic [1:0]  lay;
        logic        pad;
        logic        lsf;
        int unsigned rate;
        int unsigned kbps;
        int unsigned len;
        res.status = mah_pkg::ST_INVALID;
        res.length = '0;
        br_idx = w[15:12];
        sr_idx = w[11:10];
        lay    = w[18:17];
        pad    = w[9];

        if (w[31:8] == mah_pkg::TAG_WORD)
        begin
            res.status = mah_pkg::ST_TAG;
            res.length = mah_pkg::TAG_LENGTH;
            return res;
        end
        if ((w & SYNC_BITS) != SYNC_BITS || br_idx == mah_pkg::BR_BAD ||
            sr_idx == mah_pkg::SR_BAD || lay == mah_pkg::LAY_BAD)
            return res;

        // MPEG1 base rates; LSF halves them, MPEG2.5 quarters them
        case (sr_idx)
            2'd0:    rate = 44100;
            2'd1:    rate = 48000;
            default: rate = 32000;
        endcase
        if (!w[20])
            rate = rate >> 2;
        else if (!w[19])
            rate = rate >> 1;
        lsf  = !(w[20] && w[19]);
        kbps = kbps_of(lsf, lay, br_idx);

        if (br_idx == mah_pkg::BR_FREE)
        begin
            res.status = (lay == mah_pkg::LAY_L3) ? mah_pkg::ST_FREE_L3 : mah_pkg::ST_FRAME;
            return res;
        end

        case (lay)
            mah_pkg::LAY_L1: len = ((kbps * L1_SLOT_SCALE) / rate + pad) * 4;
            mah_pkg::LAY_L2: len = (kbps * L23_SLOT_SCALE) / rate + pad;
            default:         len = (kbps * L23_SLOT_SCALE) / (rate << lsf) + pad;
        endcase
        res.status = mah_pkg::ST_FRAME;
        res.length = len[11:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic add_row(input logic [31:0] w, input bit typed,
                           input logic [1:0] st, input logic [11:0] len);
        hdr_row_t row;
        row.word       = w;
        row.typed      = typed;
        row.res.status = st;
        row.res.length = len;
        header_rows.push_back(row);
    endtask

    // Mostly short gaps, now and then a long one; none while calm
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Mix of tags, raw noise, broken sync and well-formed headers
    function automatic logic [31:0] random_word();
        logic [31:0] w;
        int unsigned r;
        r = $urandom_range(0, 99);
        w = $urandom;
        if (r < 8)
            w = {mah_pkg::TAG_WORD, w[7:0]};
        else if (r < 20)
            w = w;
        else if (r < 30)
        begin
            w = w | SYNC_BITS;
            w[$urandom_range(21, 31)] = 1'b0;
        end
        else
        begin
            w = w | SYNC_BITS;
            // most sync words get legal fields so the length math is exercised
            if ($urandom_range(0, 99) < 85)
            begin
                if (w[15:12] == mah_pkg::BR_BAD)
                    w[15:12] = 4'($urandom_range(0, 14));
                if (w[11:10] == mah_pkg::SR_BAD)
                    w[11:10] = 2'($urandom_range(0, 2));
                if (w[18:17] == mah_pkg::LAY_BAD)
                    w[18:17] = 2'($urandom_range(1, 3));
            end
        end
        return w;
    endfunction

    // Present one word, hold it until the transfer, then queue its decode
    task automatic send_word(input logic [31:0] w, input bit typed, input hdr_result_t typed_res);
        int unsigned gap;
        hdr_expect_t exp_item;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        header_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_item.word = w;
        exp_item.res  = typed ? typed_res : predict_header(w);
        pending_headers.push_back(exp_item);
    endtask

    // ------------------------------------------------------------------
    // Result sink: random backpressure, short and long stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_hold > 0)
            sink_hold <= sink_hold - 1;
        else if (calm)
            out_ready <= 1'b1;
        else
        begin
            sink_roll = $urandom_range(0, 99);
            if (sink_roll < 60)
            begin
                out_ready <= 1'b1;
                sink_hold <= $urandom_range(0, 4);
            end
            else if (sink_roll < 92)
            begin
                out_ready <= 1'b0;
                sink_hold <= $urandom_range(0, 3);
            end
            else
            begin
                out_ready <= 1'b0;
                sink_hold <= $urandom_range(8, 40);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each output transfer against the oldest decode
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_headers.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: status %0d length %0d",
                             status, frame_length);
            end
            else
            begin
                if (status !== pending_headers[0].res.status ||
                    frame_length !== pending_headers[0].res.length)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("mismatch word %h: status exp %0d got %0d, length exp %0d got %0d",
                                 pending_headers[0].word, pending_headers[0].res.status,
                                 status, pending_headers[0].res.length, frame_length);
                end
                pending_headers.delete(0);
            end
        end
    end

    // Watchdog: too many cycles without any transfer means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        hdr_row_t    row;
        hdr_result_t none;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        header_word = '0;
        out_ready   = 1'b0;
        calm        = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        sink_hold   = 0;
        none        = '0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table. Tag, reject and free-format rows are typed in;
        // real frame lengths come from the predictor.
        add_row(32'h54414700, 1, mah_pkg::ST_TAG, mah_pkg::TAG_LENGTH); // tag, low byte zero
        add_row(32'h544147ff, 1, mah_pkg::ST_TAG, mah_pkg::TAG_LENGTH); // tag, low byte ones
        add_row(32'h00000000, 1, mah_pkg::ST_INVALID, 12'd0);
        add_row(32'hffffffff, 1, mah_pkg::ST_INVALID, 12'd0);   // bitrate index fifteen
        add_row(32'h54414800, 1, mah_pkg::ST_INVALID, 12'd0);   // almost a tag, no sync
        add_row(32'hffdb9000, 1, mah_pkg::ST_INVALID, 12'd0);   // lowest sync bit clear
        add_row(32'h7ffb9000, 1, mah_pkg::ST_INVALID, 12'd0);   // top sync bit clear
        add_row(32'hfffbf000, 1, mah_pkg::ST_INVALID, 12'd0);   // bitrate index fifteen
        add_row(32'hfffb9c00, 1, mah_pkg::ST_INVALID, 12'd0);   // reserved sample rate
        add_row(32'hfff99000, 1, mah_pkg::ST_INVALID, 12'd0);   // reserved layer
        add_row(32'hfffb0000, 1, mah_pkg::ST_FREE_L3, 12'd0);   // layer III free format
        add_row(32'hffe30200, 1, mah_pkg::ST_FREE_L3, 12'd0);   // same, MPEG2.5 padded
        add_row(32'hffff0000, 1, mah_pkg::ST_FRAME,   12'd0);   // layer I free format
        add_row(32'hfffd0200, 1, mah_pkg::ST_FRAME,   12'd0);   // layer II free, padded
        add_row(32'hfffb9000, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG1 L3 128k 44.1k
        add_row(32'hfffb9200, 0, mah_pkg::ST_FRAME,   12'd0);   // same, padded
        add_row(32'hfff39000, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG2 LSF layer III
        add_row(32'hffe39000, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG2.5, bit 19 clear
        add_row(32'hffeb9000, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG2.5, bit 19 set
        add_row(32'hffffea00, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG1 L1 448k 32k pad
        add_row(32'hfffdea00, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG1 L2 384k 32k pad
        add_row(32'hfffbea00, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG1 L3 320k 32k pad
        add_row(32'hffe5ea00, 0, mah_pkg::ST_FRAME,   12'd0);   // longest frame overall
        add_row(32'hfff71400, 0, mah_pkg::ST_FRAME,   12'd0);   // LSF L1 lowest bitrate
        add_row(32'hffe7e800, 0, mah_pkg::ST_FRAME,   12'd0);   // MPEG2.5 L1 top bitrate

        foreach (header_rows[i])
        begin
            row = header_rows[i];
            send_word(row.word, row.typed, row.res);
        end

        // Random part; calm stretches with no idling on either side
        for (int unsigned n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % CALM_SPAN == 0)
                calm <= ($urandom_range(0, 3) == 0);
            send_word(random_word(), 0, none);
        end
        in_valid <= 1'b0;

        // Drain, then give stray results time to show up
        while (pending_headers.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_headers.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
